>>> hdl/aqzt_pkg.sv
package aqzt_pkg;

  localparam int MAX_WORKERS_DEF = 16;

  localparam int GREEN_W = 30;
  localparam int ZONE_W  = 31;
  localparam int TIME_W  = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam int WC_W = 5;
  localparam int PT_W = 10;
  localparam int IDX_W = 4;

  // dividend width of the step divider: the yellow-green span
  localparam int DIV_W = ZONE_W;
  localparam int DEC_DIVISOR = 10;

  // floor(n/10) = (n * RECIP10) >> RECIP10_SH for any n below 2^32
  localparam logic [31:0] RECIP10    = 32'hCCCC_CCCD;
  localparam int          RECIP10_SH = 35;
  localparam int          GPROD_W    = ZONE_W + 32;

  localparam logic [GREEN_W-1:0] GREEN_MAX = {GREEN_W{1'b1}};
  localparam logic [ZONE_W-1:0]  ZONE_MAX  = {ZONE_W{1'b1}};

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_INITIAL_GREEN    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_YELLOW_FLOOR     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WORKER_COUNT     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PARALLEL_THREADS = 2'd3;

  // register reset values
  localparam logic [GREEN_W-1:0] INITIAL_GREEN_RST    = 30'd8;
  localparam logic [ZONE_W-1:0]  YELLOW_FLOOR_RST     = 31'd0;
  localparam logic [WC_W-1:0]    WORKER_COUNT_RST     = 5'd1;
  localparam logic [PT_W-1:0]    PARALLEL_THREADS_RST = 10'd8;

  // green update kinds
  localparam logic [1:0] GOP_HOLD   = 2'd0;
  localparam logic [1:0] GOP_SHRINK = 2'd1;
  localparam logic [1:0] GOP_GROW   = 2'd2;

  typedef struct packed {
    logic [TIME_W-1:0] update_time;
    logic [TIME_W-1:0] goal_time;
    logic [ZONE_W-1:0] processed_buffers;
  } in_beat_t;

  typedef struct packed {
    logic [IDX_W-1:0]   worker_index;
    logic               worker_valid;
    logic [ZONE_W-1:0]  activate_level;
    logic [ZONE_W-1:0]  deactivate_level;
    logic [GREEN_W-1:0] green_level;
    logic [ZONE_W-1:0]  yellow_level;
    logic [ZONE_W-1:0]  red_level;
    logic               last;
  } out_beat_t;

  typedef struct packed {
    logic accept;
    logic gdiv_start;
    logic green_upd;
    logic zone_calc;
    logic ddiv_start;
    logic emit_init;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic green_hold;
    logic div_done;
    logic w_zero;
    logic last_worker;
    logic out_free;
  } sts_t;

endpackage

>>> hdl/aqzt_div.sv
module aqzt_div import aqzt_pkg::*; #(
  parameter int DW = DIV_W,
  parameter int VW = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          done,
  output logic [DW-1:0] quot,
  output logic [VW-1:0] rem
);

  localparam int CW = $clog2(DW);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [VW-1:0] dvs;
  logic [VW:0]   shifted;
  logic [VW:0]   trial;
  logic          fits;

  // restoring division, one quotient bit per cycle
  assign shifted = {rem, quot[DW-1]};
  assign trial   = shifted - {1'b0, dvs};
  assign fits    = ~trial[VW];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(DW - 1);
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quot <= dividend;
      rem  <= '0;
      dvs  <= divisor;
    end else if (busy) begin
      quot <= {quot[DW-2:0], fits};
      rem  <= fits ? trial[VW-1:0] : shifted[VW-1:0];
    end
  end

endmodule

>>> hdl/aqzt_dp.sv
module aqzt_dp import aqzt_pkg::*; #(
  parameter int MAX_WORKERS = MAX_WORKERS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  cmd_t                  cmd,
  output sts_t                  sts,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  in_beat_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_beat_t             out_data
);

  localparam int WW = $clog2(MAX_WORKERS + 1);
  localparam int VW = (WW > 4) ? WW : 4;

  // configuration and state
  logic [ZONE_W-1:0]  yellow_floor;
  logic [WC_W-1:0]    worker_count;
  logic [PT_W-1:0]    parallel_threads;
  logic [GREEN_W-1:0] green_state;

  // per update
  logic [1:0]         gop;
  logic [GPROD_W-1:0] gprod;
  logic               gmul_done;
  logic [ZONE_W-1:0]  yellow;
  logic [ZONE_W-1:0]  red;
  logic [ZONE_W-1:0]  span;
  logic [WW-1:0]      wsat;
  logic               cap;

  // worker walk
  logic [WW-1:0]      idx;
  logic [ZONE_W-1:0]  acc_q;
  logic [VW-1:0]      acc_r;
  logic [ZONE_W-1:0]  step_q;
  logic [VW-1:0]      step_r;

  // divider
  logic               div_start;
  logic [DIV_W-1:0]   div_dividend;
  logic [VW-1:0]      div_divisor;
  logic               div_done;
  logic [DIV_W-1:0]   div_quot;
  logic [VW-1:0]      div_rem;

  // combinational
  logic [1:0]         gop_next;
  logic [ZONE_W-1:0]  g_op;
  logic [ZONE_W-1:0]  tenth;
  logic [GREEN_W-1:0] green_next;
  logic [ZONE_W-1:0]  grow_q;
  logic [ZONE_W-1:0]  grow_p1;
  logic [ZONE_W-1:0]  grow_mx;
  logic [ZONE_W-1:0]  twice_g;
  logic [ZONE_W-1:0]  gap;
  logic [ZONE_W+1:0]  ysum;
  logic [ZONE_W-1:0]  y_next;
  logic [ZONE_W+1:0]  rsum;
  logic [WW-1:0]      w_next;
  logic [ZONE_W+1:0]  cap_lhs;
  logic [ZONE_W+1:0]  cap_rhs;
  logic [VW:0]        r_sum;
  logic               wrap;
  logic [VW-1:0]      r_next;
  logic [ZONE_W-1:0]  q_next;
  logic [ZONE_W-1:0]  act;
  logic [PT_W-1:0]    half_p;
  logic [PT_W:0]      p_plus1;
  out_beat_t          beat;

  always_comb begin
    if (in_data.update_time > in_data.goal_time) begin
      gop_next = GOP_SHRINK;
    end else if (in_data.update_time < in_data.goal_time &&
                 in_data.processed_buffers > ZONE_W'(green_state)) begin
      gop_next = GOP_GROW;
    end else begin
      gop_next = GOP_HOLD;
    end
  end

  // shrink needs ceil(green/10), grow needs floor(green/10)
  assign g_op  = ZONE_W'(green_state) +
                 ((gop == GOP_SHRINK) ? ZONE_W'(DEC_DIVISOR - 1) : '0);
  assign tenth = ZONE_W'(gprod[GPROD_W-1:RECIP10_SH]);

  // green from the tenth: g - ceil(g/10) or max(g + floor(g/10), g + 1)
  always_comb begin
    grow_q  = ZONE_W'(green_state) + tenth;
    grow_p1 = ZONE_W'(green_state) + 1'b1;
    grow_mx = (grow_q > grow_p1) ? grow_q : grow_p1;
    if (gop == GOP_SHRINK) begin
      green_next = green_state - tenth[GREEN_W-1:0];
    end else if (grow_mx > ZONE_W'(GREEN_MAX)) begin
      green_next = GREEN_MAX;
    end else begin
      green_next = grow_mx[GREEN_W-1:0];
    end
  end

  // zone levels
  always_comb begin
    twice_g = {green_state, 1'b0};
    gap     = (twice_g > yellow_floor) ? twice_g : yellow_floor;
    ysum    = (ZONE_W+2)'(green_state) + (ZONE_W+2)'(gap);
    y_next  = (ysum > (ZONE_W+2)'(ZONE_MAX)) ? ZONE_MAX : ysum[ZONE_W-1:0];
    rsum    = (ZONE_W+2)'({y_next, 1'b0}) - (ZONE_W+2)'(green_state);
    if (32'(worker_count) > 32'(MAX_WORKERS)) begin
      w_next = WW'(MAX_WORKERS);
    end else begin
      w_next = WW'(worker_count);
    end
  end

  assign cap_lhs = (ZONE_W+2)'({span, 1'b0});
  assign cap_rhs = (ZONE_W+2)'(parallel_threads) * (ZONE_W+2)'(wsat);

  // running floor(span*i/w) as quotient and remainder
  always_comb begin
    r_sum   = {1'b0, acc_r} + {1'b0, step_r};
    wrap    = (r_sum >= (VW+1)'(wsat));
    r_next  = wrap ? VW'(r_sum - (VW+1)'(wsat)) : r_sum[VW-1:0];
    q_next  = acc_q + step_q + ZONE_W'(wrap);
    p_plus1 = (PT_W+1)'(parallel_threads) + 1'b1;
    half_p  = p_plus1[PT_W:1];
    if (idx == '0 && cap) begin
      act = ZONE_W'(half_p);
    end else begin
      act = q_next + ZONE_W'(r_next != '0);
    end
  end

  always_comb begin
    beat.green_level  = green_state;
    beat.yellow_level = yellow;
    beat.red_level    = red;
    if (wsat == '0) begin
      beat.worker_index     = '0;
      beat.worker_valid     = 1'b0;
      beat.activate_level   = '0;
      beat.deactivate_level = '0;
      beat.last             = 1'b1;
    end else begin
      beat.worker_index     = IDX_W'(idx);
      beat.worker_valid     = 1'b1;
      beat.activate_level   = ZONE_W'((ZONE_W+1)'(green_state) + (ZONE_W+1)'(act));
      beat.deactivate_level = ZONE_W'((ZONE_W+1)'(green_state) + (ZONE_W+1)'(acc_q));
      beat.last             = (idx == WW'(wsat - 1'b1));
    end
  end

  assign div_start    = cmd.ddiv_start;
  assign div_dividend = DIV_W'(span);
  assign div_divisor  = VW'(wsat);

  aqzt_div #(
    .DW (DIV_W),
    .VW (VW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      yellow_floor     <= YELLOW_FLOOR_RST;
      worker_count     <= WORKER_COUNT_RST;
      parallel_threads <= PARALLEL_THREADS_RST;
      green_state      <= INITIAL_GREEN_RST;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_INITIAL_GREEN:    green_state      <= cfg_data[GREEN_W-1:0];
          REG_YELLOW_FLOOR:     yellow_floor     <= cfg_data[ZONE_W-1:0];
          REG_WORKER_COUNT:     worker_count     <= cfg_data[WC_W-1:0];
          REG_PARALLEL_THREADS: parallel_threads <= cfg_data[PT_W-1:0];
          default: ;
        endcase
      end else if (cmd.green_upd) begin
        green_state <= green_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      gop <= gop_next;
    end
    if (cmd.gdiv_start) begin
      gprod <= GPROD_W'(g_op) * GPROD_W'(RECIP10);
    end
    if (cmd.zone_calc) begin
      yellow <= y_next;
      red    <= (rsum > (ZONE_W+2)'(ZONE_MAX)) ? ZONE_MAX : rsum[ZONE_W-1:0];
      span   <= y_next - ZONE_W'(green_state);
      wsat   <= w_next;
    end
    if (cmd.ddiv_start) begin
      cap <= (cap_lhs > cap_rhs);
    end
    if (cmd.emit_init) begin
      step_q <= div_quot[ZONE_W-1:0];
      step_r <= div_rem;
      acc_q  <= '0;
      acc_r  <= '0;
      idx    <= '0;
    end else if (cmd.emit) begin
      acc_q <= q_next;
      acc_r <= r_next;
      idx   <= idx + 1'b1;
    end
    if (cmd.emit) begin
      out_data <= beat;
    end
  end

  // the tenth product is registered, and ready in the cycle after it is started
  always_ff @(posedge clk) begin
    if (rst) begin
      gmul_done <= 1'b0;
    end else begin
      gmul_done <= cmd.gdiv_start;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  assign sts.green_hold  = (gop == GOP_HOLD);
  assign sts.div_done    = div_done | gmul_done;
  assign sts.w_zero      = (wsat == '0);
  assign sts.last_worker = beat.last;
  assign sts.out_free    = ~out_valid | ~out_stall;

endmodule

>>> hdl/aqzt_ctrl.sv
module aqzt_ctrl import aqzt_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_GSEL   = 3'd1;
  localparam logic [2:0] S_GWAIT  = 3'd2;
  localparam logic [2:0] S_ZONE   = 3'd3;
  localparam logic [2:0] S_DSTART = 3'd4;
  localparam logic [2:0] S_DWAIT  = 3'd5;
  localparam logic [2:0] S_EMIT   = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = S_GSEL;
        end
      end
      S_GSEL: begin
        if (sts.green_hold) begin
          state_next = S_ZONE;
        end else begin
          cmd.gdiv_start = 1'b1;
          state_next     = S_GWAIT;
        end
      end
      S_GWAIT: begin
        if (sts.div_done) begin
          cmd.green_upd = 1'b1;
          state_next    = S_ZONE;
        end
      end
      S_ZONE: begin
        cmd.zone_calc = 1'b1;
        state_next    = S_DSTART;
      end
      S_DSTART: begin
        if (sts.w_zero) begin
          state_next = S_EMIT;
        end else begin
          cmd.ddiv_start = 1'b1;
          state_next     = S_DWAIT;
        end
      end
      S_DWAIT: begin
        if (sts.div_done) begin
          cmd.emit_init = 1'b1;
          state_next    = S_EMIT;
        end
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          if (sts.last_worker) begin
            state_next = S_IDLE;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

>>> hdl/adaptive_queue_zone_thresholds.sv
// Adaptive queue zone thresholds. Each input beat is one measurement (time
// spent, goal time, buffers processed); it moves the green queue level down
// by a tenth, up by a tenth (at least one, capped at 2^30-1) or leaves it,
// derives yellow and red from it, and then sends one result beat per worker
// with that worker's activate and deactivate levels, the last one marked by
// last. A worker count of zero gives one beat with worker_valid low; a count
// above MAX_WORKERS is taken as MAX_WORKERS. Rate: one update at a time; a
// new measurement is not taken before the last one is through. With the
// saturated worker count zero there is no step division, and result stalls
// hold the worker walk. The step divider resolves one quotient bit per cycle
// over 31 bits; the tenth of green comes from one reciprocal multiplication,
// and the worker levels then come out at one beat a cycle, while the result
// channel is not stalled, from a running quotient and remainder. The next
// measurement is taken as soon as the last result beat sits in the output
// register. Configuration writes are always ready; they belong to idle time,
// a rule the user must keep, as the block does not enforce it; writing
// initial_green also reloads the green level.
module adaptive_queue_zone_thresholds import aqzt_pkg::*; #(
  parameter int MAX_WORKERS = MAX_WORKERS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  // measurement channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_beat_t              in_data,
  // result channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_beat_t             out_data,
  // register writes
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cmd_t cmd;
  sts_t sts;

  // registers are plain flops, a write never has to wait
  assign cfg_ready = 1'b1;

  // sequencer: measurement in, green update, zones, step division, worker walk
  aqzt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // arithmetic, registers, step divider and output register
  aqzt_dp #(
    .MAX_WORKERS (MAX_WORKERS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .cfg_we    (cfg_valid & cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // one update at a time: a taken measurement closes the input
  a_one_update: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("measurement taken while an update was running");

  // the no-worker beat is the only beat of its update
  a_zero_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data.worker_valid) |-> out_data.last)
    else $error("beat without worker is not last");

  // a worker never starts below the level where it stops
  a_hysteresis: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.activate_level >= out_data.deactivate_level))
    else $error("activate level below deactivate level");

  // zones stay ordered
  a_zone_order: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.red_level >= out_data.yellow_level &&
                   out_data.yellow_level >= 31'(out_data.green_level)))
    else $error("zone levels out of order");

endmodule
